// ===== sv/sobel_pkg.sv =====
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared constants and types for the RGB Sobel edge block.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int MaxWidth  = 1024;
    localparam int ColW      = $clog2(MaxWidth);   // line store address bits
    localparam int RowCap    = 16383;
    localparam int PixW      = 24;

    // configuration register indexes
    localparam logic [0:0] RegFrameWidth  = 1'b0;
    localparam logic [0:0] RegFrameHeight = 1'b1;

    // work handed from the front end to the back end
    typedef struct packed {
        logic [PixW-1:0] pix;
        logic [ColW-1:0] idx;
        logic            emit;
        logic [2:0]      rv;
        logic [2:0]      cv;
        logic            frame_end;
    } sobel_job_t;

    // back end sequencer
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_READ,
        PH_SUM,
        PH_ROOT,
        PH_ROUND,
        PH_HOLD
    } sobel_phase_t;

endpackage

// ===== sv/sobel_edge_magnitude_rgb.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel edge magnitude on RGB pixels.
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  s_      | in        | pixel + flush
//  m_      | out       | edge magnitude + frame end
//  cfg_    | in        | register write (0 width, 1 height)
//
// The back end takes one job at a time. A transaction with a result holds it
// through hand-over, store read and window shift, sum of squares, 11 root
// steps and rounding, then the result waits until m_tready. A transaction
// without a result frees it after the store read and window shift. A two-entry
// queue accepts ahead of the back end; s_tready drops only while the queue is full.
// Reset is synchronous, active low; line stores are not cleared.
module sobel_edge_magnitude_rgb import sobel_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
    input  logic        s_tuser,   // flush
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    output logic        m_tlast,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        f_valid, f_ready, b_valid, b_ready;
    sobel_job_t  f_job, b_job;
    logic [PixW-1:0] pix, opix;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                RegFrameWidth:  width_reg  <= cfg_data[10:0];
                RegFrameHeight: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // model packs red high
    assign pix = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    sobel_front u_front (
        .aclk(aclk), .aresetn(aresetn), .frame_width(width_reg), .frame_height(height_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_pix(pix), .in_flush(s_tuser),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

    sobel_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_data(f_job), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job));

    sobel_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(b_valid), .job_ready(b_ready),
        .job(b_job), .out_valid(m_tvalid), .out_ready(m_tready), .out_pix(opix),
        .out_end(m_tlast));

    assign m_tdata = {opix[7:0], opix[15:8], opix[23:16]};
endmodule

// ===== sv/sobel_ram.sv =====
// ----------------------------------------------------------------------------
// sobel_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sobel_ram #(
    parameter int Width = 24,
    parameter int Depth = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end
endmodule

// ===== sv/sobel_front.sv =====
// ----------------------------------------------------------------------------
// sobel_front
// Accepts pixels, tracks frame position and classifies each item.
// ----------------------------------------------------------------------------
module sobel_front import sobel_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [10:0]     frame_width,
    input  logic [12:0]     frame_height,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [PixW-1:0] in_pix,
    input  logic            in_flush,
    output logic            job_valid,
    input  logic            job_ready,
    output sobel_job_t      job
);
    logic [10:0] col_reg,  col_next;
    logic [13:0] row_reg,  row_next;
    logic [11:0] pend_reg, pend_next;
    logic [10:0] w;
    logic [12:0] h;
    logic        flushing, emit, fend, go;
    logic signed [15:0] r, c, rr, cc;
    logic [2:0]  rv, cv;
    logic [10:0] col_inc;

    always_comb begin
        w = (frame_width == '0) ? 11'd1 :
            (frame_width > 11'(MaxWidth)) ? 11'(MaxWidth) : frame_width;
        h = (frame_height == '0) ? 13'd1 : frame_height;
    end

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign go        = in_valid && job_ready;

    always_comb begin
        flushing = in_flush || (row_reg >= 14'(h));
        emit     = pend_reg >= 12'(w) + 12'd1;
        if (col_reg != '0) begin
            r = 16'(row_reg) - 16'sd1;
            c = 16'(col_reg) - 16'sd1;
        end else begin
            r = 16'(row_reg) - 16'sd2;
            c = 16'(w) - 16'sd1;
        end
        for (int k = 0; k < 3; k++) begin
            rr    = r - 16'sd1 + 16'(k);
            cc    = c - 16'sd1 + 16'(k);
            rv[k] = (rr >= 0) && (rr < $signed(16'(h)));
            cv[k] = (cc >= 0) && (cc < $signed(16'(w)));
        end
        fend = emit && (r >= $signed(16'(h)) - 16'sd1) && (c >= $signed(16'(w)) - 16'sd1);

        job.pix       = flushing ? '0 : in_pix;
        job.idx       = (col_reg < 11'(MaxWidth)) ? col_reg[ColW-1:0] : ColW'(MaxWidth - 1);
        job.emit      = emit;
        job.rv        = rv;
        job.cv        = cv;
        job.frame_end = fend;

        col_inc   = col_reg + 11'd1;
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        if (go) begin
            if (!emit) pend_next = pend_reg + 12'd1;
            if (fend) begin
                col_next  = '0;
                row_next  = '0;
                pend_next = '0;
            end else if (col_inc >= w) begin
                col_next = '0;
                if (row_reg < 14'(RowCap)) row_next = row_reg + 14'd1;
            end else begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end
endmodule

// ===== sv/sobel_queue.sv =====
// ----------------------------------------------------------------------------
// sobel_queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module sobel_queue import sobel_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  sobel_job_t wr_data,
    output logic       rd_valid,
    input  logic       rd_ready,
    output sobel_job_t rd_data
);
    sobel_job_t  q_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = q_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) q_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule

// ===== sv/sobel_back.sv =====
// ----------------------------------------------------------------------------
// sobel_back
// Line stores, 3x3 window and magnitude pipeline. Sequencer per job: read the
// stores, shift the window and, on emit, sum of squares, root, round, present.
// ----------------------------------------------------------------------------
module sobel_back import sobel_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            job_valid,
    output logic            job_ready,
    input  sobel_job_t      job,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [PixW-1:0] out_pix,
    output logic            out_end
);
    sobel_phase_t       ph_reg, ph_next;
    sobel_job_t         job_reg;
    logic [PixW-1:0]    win_reg [9];
    logic [PixW-1:0]    up_rd, mid_rd;
    logic [PixW-1:0]    pix_reg;
    logic               end_reg;
    logic               start;
    // per channel remainder and partial root; sum < 2*1020^2 < 2^21
    logic [21:0]        rem_reg [3], rem_next [3];
    logic [21:0]        root_reg [3], root_next [3];
    logic [21:0]        bit_reg, bit_next;
    logic [7:0]         v [9];
    logic signed [11:0] gx, gy;
    logic signed [21:0] gxe, gye;
    logic [21:0]        s, trial;
    logic [11:0]        rnd;
    logic [PixW-1:0]    mag;

    assign job_ready = (ph_reg == PH_IDLE);
    assign start     = job_valid && job_ready;

    sobel_ram #(.Width(PixW), .Depth(MaxWidth)) u_upper (
        .aclk(aclk), .we(ph_reg == PH_READ), .waddr(job_reg.idx), .wdata(mid_rd),
        .re(start), .raddr(job.idx), .rdata(up_rd));
    sobel_ram #(.Width(PixW), .Depth(MaxWidth)) u_middle (
        .aclk(aclk), .we(ph_reg == PH_READ), .waddr(job_reg.idx), .wdata(job_reg.pix),
        .re(start), .raddr(job.idx), .rdata(mid_rd));

    always_comb begin
        ph_next = ph_reg;
        unique case (ph_reg)
            PH_IDLE:  if (start) ph_next = PH_READ;
            PH_READ:  ph_next = job_reg.emit ? PH_SUM : PH_IDLE;
            PH_SUM:   ph_next = PH_ROOT;
            PH_ROOT:  if (bit_reg == 22'd1) ph_next = PH_ROUND;
            PH_ROUND: ph_next = PH_HOLD;
            PH_HOLD:  if (out_ready) ph_next = PH_IDLE;
            default:  ph_next = PH_IDLE;
        endcase
    end

    assign out_valid = (ph_reg == PH_HOLD);
    assign out_pix   = pix_reg;
    assign out_end   = end_reg;

    // sum of squares on the updated window, then one restoring root step a
    // cycle; the remainder left over decides the round up
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 9; i++)
                v[i] = (job_reg.rv[i/3] && job_reg.cv[i%3]) ?
                       win_reg[i][16-8*ch +: 8] : 8'd0;
            gx = 12'(v[2]) + 12'(v[5]) * 12'd2 + 12'(v[8])
               - 12'(v[0]) - 12'(v[3]) * 12'd2 - 12'(v[6]);
            gy = 12'(v[6]) + 12'(v[7]) * 12'd2 + 12'(v[8])
               - 12'(v[0]) - 12'(v[1]) * 12'd2 - 12'(v[2]);
            gxe = 22'(gx);
            gye = 22'(gy);
            s   = 22'(gxe * gxe) + 22'(gye * gye);

            trial         = root_reg[ch] + bit_reg;
            rem_next[ch]  = rem_reg[ch];
            root_next[ch] = root_reg[ch];
            if (ph_reg == PH_SUM) begin
                rem_next[ch]  = s;
                root_next[ch] = '0;
            end else if (ph_reg == PH_ROOT) begin
                if (rem_reg[ch] >= trial) begin
                    rem_next[ch]  = rem_reg[ch] - trial;
                    root_next[ch] = (root_reg[ch] >> 1) + bit_reg;
                end else begin
                    root_next[ch] = root_reg[ch] >> 1;
                end
            end

            rnd = 12'(root_reg[ch]) + 12'(rem_reg[ch] > root_reg[ch]);
            mag[16-8*ch +: 8] = (rnd > 12'd255) ? 8'hFF : rnd[7:0];
        end
        bit_next = bit_reg;
        if (ph_reg == PH_SUM) bit_next = 22'h100000;   // 4^10, top root bit
        else if (ph_reg == PH_ROOT) bit_next = bit_reg >> 2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_IDLE;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end else begin
            ph_reg <= ph_next;
            if (ph_reg == PH_READ) begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2] <= up_rd;
                win_reg[5] <= mid_rd;
                win_reg[8] <= job_reg.pix;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) job_reg <= job;
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < 3; ch++) begin
            rem_reg[ch]  <= rem_next[ch];
            root_reg[ch] <= root_next[ch];
        end
        bit_reg <= bit_next;
        if (ph_reg == PH_ROUND) begin
            pix_reg <= mag;
            end_reg <= job_reg.frame_end;
        end
    end
endmodule

// ===== sv/sobel_checker.sv =====
// ----------------------------------------------------------------------------
// sobel_checker
// Port-level checks on the Sobel edge block.
// ----------------------------------------------------------------------------
module sobel_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("back-to-back results");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result after reset");
    a_rdy: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");
endmodule

bind sobel_edge_magnitude_rgb sobel_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast));
